[rtl/ccnd_pkg.sv]
// Shared constants and types for the character-cell normalizer.
// No dependencies; imported by every other file of the block.
`default_nettype none

package ccnd_pkg;

	// Delay line depth in cells (two rows of forty cells).
	localparam int DELAY_CELLS = 80;
	localparam int PosW        = (DELAY_CELLS > 1) ? $clog2(DELAY_CELLS) : 1;

	localparam int ColorW   = 8;
	localparam int PatternW = 64;

	typedef logic [PosW-1:0] pos_t;

	// One stored cell: pattern above colour.
	typedef struct packed {
		logic [PatternW-1:0] pattern;
		logic [ColorW-1:0]   color;
	} cell_t;

	// Normalizer result.
	typedef struct packed {
		cell_t body;
		logic  single;
	} norm_t;

endpackage

`default_nettype wire

[rtl/char_cell_normalize_delta_flags.sv]
// Top level of the character-cell normalizer with delta flags.
// Depends on ccnd_pkg, ccnd_norm and ccnd_delay_ram.
//
//  Channel | Direction | tdata (low bit up)                   | tuser
//  --------+-----------+--------------------------------------+---------------------------------
//  s_axis  | in        | cell_color[7:0], cell_pattern[71:8]  | wild_allowed
//  m_axis  | out       | out_color[7:0], out_pattern[71:8]    | color_changed, pattern_changed
//
// Output valid rises once an input transfer has passed stage 1 into the output register,
// and stage 1 waits while that register is full; one cell per cycle sustained while
// m_axis_tready stays high, set by the single read and single write port of the delay memory.
// Stage 1 holds the normalized cell while the delay entry is read; the output
// register compares, writes back and presents the result. A full output register
// stalls stage 1 only when m_axis_tready is low.
// Reset clears the write position and per-entry valid bits at once; unwritten
// entries read as a zero cell, so no clearing pass is needed.
`default_nettype none

module char_cell_normalize_delta_flags
	import ccnd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,   // [7:0] cell_color, [71:8] cell_pattern
	input  wire logic        s_axis_tuser,   // [0] wild_allowed

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,   // [7:0] out_color, [71:8] out_pattern
	output logic [1:0]       m_axis_tuser    // [0] color_changed, [1] pattern_changed
);

	// ---------------------------------------------------------------
	// handshake
	// ---------------------------------------------------------------
	logic  in_xfer;
	logic  s1_adv;
	logic  valid_s1;
	logic  out_valid_q;

	assign s1_adv        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_adv;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// ---------------------------------------------------------------
	// normalize on the way in
	// ---------------------------------------------------------------
	norm_t norm;

	ccnd_norm u_norm (
		.color   (s_axis_tdata[7:0]),
		.pattern (s_axis_tdata[71:8]),
		.norm    (norm)
	);

	// ---------------------------------------------------------------
	// write position and entry valid bits
	// ---------------------------------------------------------------
	pos_t                   pos_q;
	logic [DELAY_CELLS-1:0] entry_vld_q;

	// stage 1 registers
	norm_t norm_s1;
	logic  wild_s1;
	pos_t  addr_s1;
	logic  vld_s1;   // entry held a written cell at read time
	logic  fwd_s1;   // entry was being written in the read cycle

	// output register
	cell_t out_cell_q;
	logic  col_chg_q;
	logic  pat_chg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			entry_vld_q <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				pos_q <= (pos_q == pos_t'(DELAY_CELLS - 1)) ? '0 : pos_q + pos_t'(1);
			end
			if (s1_adv) begin
				entry_vld_q[addr_s1] <= 1'b1;
			end
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			norm_s1 <= norm;
			wild_s1 <= s_axis_tuser;
			addr_s1 <= pos_q;
			vld_s1  <= entry_vld_q[pos_q];
			// only possible when the line is one cell deep
			fwd_s1  <= s1_adv && (addr_s1 == pos_q);
		end
	end

	// ---------------------------------------------------------------
	// delay memory
	// ---------------------------------------------------------------
	cell_t rd_cell;
	cell_t final_cell;

	ccnd_delay_ram u_ram (
		.clk     (clk),
		.rd_en   (in_xfer),
		.rd_addr (pos_q),
		.rd_data (rd_cell),
		.wr_en   (s1_adv),
		.wr_addr (addr_s1),
		.wr_data (final_cell)
	);

	// ---------------------------------------------------------------
	// compare with the reference cell two rows back
	// ---------------------------------------------------------------
	cell_t ref_cell;
	logic  col_chg;
	logic  pat_chg;

	always_comb begin
		if (fwd_s1) begin
			ref_cell = out_cell_q;   // output register holds the just-written cell
		end else if (vld_s1) begin
			ref_cell = rd_cell;
		end else begin
			ref_cell = '0;
		end

		final_cell = norm_s1.body;
		col_chg    = (norm_s1.body.color != ref_cell.color);
		if (norm_s1.single && wild_s1) begin
			// plain cell reuses the reference pattern
			final_cell.pattern = ref_cell.pattern;
			pat_chg            = 1'b0;
		end else begin
			pat_chg = (norm_s1.body.pattern != ref_cell.pattern);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_cell_q <= final_cell;
			col_chg_q  <= col_chg;
			pat_chg_q  <= pat_chg;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_cell_q.pattern, out_cell_q.color};
	assign m_axis_tuser  = {pat_chg_q, col_chg_q};

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= pos_t'(DELAY_CELLS - 1))
		else $error("write position out of range");

	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_s1 |-> out_valid_q)
		else $error("forward from empty output register");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("stage 1 advance lost");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty stage 1");

	a_addr_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> addr_s1 == $past(pos_q))
		else $error("stage 1 address mismatch");
`endif

endmodule

`default_nettype wire

[rtl/ccnd_norm.sv]
// Cell normalizer: blanking, inversion with nibble swap, blank-colour fixup.
// Depends on ccnd_pkg.
`default_nettype none

module ccnd_norm
	import ccnd_pkg::*;
(
	input  wire logic [ColorW-1:0]   color,
	input  wire logic [PatternW-1:0] pattern,
	output norm_t                    norm
);

	logic [ColorW-1:0]   col_a;
	logic [PatternW-1:0] pat_a;
	logic [ColorW-1:0]   col_b;
	logic                single_b;

	always_comb begin
		col_a = color;
		pat_a = pattern;
		if (color[7:4] == color[3:0]) begin
			pat_a = '0;
		end else if (pattern[PatternW-1]) begin
			// inverted form keeps the top bit clear
			pat_a = ~pattern;
			col_a = {color[3:0], color[7:4]};
		end
	end

	always_comb begin
		col_b = col_a;
		if (pat_a == '0) begin
			col_b = {col_a[3:0], col_a[3:0]};
		end
		single_b = (col_b[7:4] == col_b[3:0]);
	end

	assign norm.body.color   = col_b;
	assign norm.body.pattern = single_b ? '0 : pat_a;
	assign norm.single       = single_b;

endmodule

`default_nettype wire

[rtl/ccnd_delay_ram.sv]
// Delay line storage: one write port, one read port, registered read data.
// Depends on ccnd_pkg. Content is undefined until written; the top masks it.
`default_nettype none

module ccnd_delay_ram
	import ccnd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  rd_en,
	input  wire pos_t  rd_addr,
	output cell_t      rd_data,
	input  wire logic  wr_en,
	input  wire pos_t  wr_addr,
	input  wire cell_t wr_data
);

	cell_t mem [DELAY_CELLS];
	cell_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire
